// File: sv/ctsw_pkg.sv
// Shared types, constants and token helpers for the step-count announcer.
// Used by the front, queue, back and top-level modules; no dependencies.
package ctsw_pkg;

	localparam int COUNT_W     = 24;
	localparam int NUM_DIGITS  = 7;
	localparam int DIGIT_W     = 4;
	localparam int TOKEN_W     = 6;
	localparam int VOL_W       = 7;
	localparam int ATT_W       = 8;
	localparam int NUM_SLOTS   = 14;
	localparam int SLOT_W      = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int BITS_PER_IT = 2;
	localparam int CONV_ITERS  = COUNT_W / BITS_PER_IT;
	localparam int ITER_W      = $clog2(CONV_ITERS);

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(9999999);
	localparam logic [VOL_W-1:0]   VOL_RESET = VOL_W'(100);
	localparam logic [VOL_W-1:0]   VOL_FULL  = VOL_W'(100);

	// Word token codes.
	localparam logic [TOKEN_W-1:0] TOK_HAI_FATTO  = TOKEN_W'(0);
	localparam logic [TOKEN_W-1:0] TOK_PASSI      = TOKEN_W'(1);
	localparam logic [TOKEN_W-1:0] TOK_ZERO       = TOKEN_W'(2);
	localparam logic [TOKEN_W-1:0] TOK_UNIT_BASE  = TOKEN_W'(2);
	localparam logic [TOKEN_W-1:0] TOK_TENS_BASE  = TOKEN_W'(10);
	localparam logic [TOKEN_W-1:0] TOK_TEEN_BASE  = TOKEN_W'(20);
	localparam logic [TOKEN_W-1:0] TOK_CENTO      = TOKEN_W'(30);
	localparam logic [TOKEN_W-1:0] TOK_MILLE      = TOKEN_W'(31);
	localparam logic [TOKEN_W-1:0] TOK_MILA       = TOKEN_W'(32);
	localparam logic [TOKEN_W-1:0] TOK_MILIONE    = TOKEN_W'(33);
	localparam logic [TOKEN_W-1:0] TOK_MILIONI    = TOKEN_W'(34);
	localparam logic [TOKEN_W-1:0] TOK_HAI_VINTO  = TOKEN_W'(35);

	// Token slots, in spoken order. Each item fills a subset of them.
	localparam logic [SLOT_W-1:0] SLOT_HEAD      = SLOT_W'(0);
	localparam logic [SLOT_W-1:0] SLOT_ZERO      = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_MIL_UNIT  = SLOT_W'(2);
	localparam logic [SLOT_W-1:0] SLOT_MIL_WORD  = SLOT_W'(3);
	localparam logic [SLOT_W-1:0] SLOT_HTH_UNIT  = SLOT_W'(4);
	localparam logic [SLOT_W-1:0] SLOT_HTH_CENTO = SLOT_W'(5);
	localparam logic [SLOT_W-1:0] SLOT_TTH_TENS  = SLOT_W'(6);
	localparam logic [SLOT_W-1:0] SLOT_TH_UNIT   = SLOT_W'(7);
	localparam logic [SLOT_W-1:0] SLOT_TH_WORD   = SLOT_W'(8);
	localparam logic [SLOT_W-1:0] SLOT_HUN_UNIT  = SLOT_W'(9);
	localparam logic [SLOT_W-1:0] SLOT_HUN_CENTO = SLOT_W'(10);
	localparam logic [SLOT_W-1:0] SLOT_TEN_TENS  = SLOT_W'(11);
	localparam logic [SLOT_W-1:0] SLOT_UNIT      = SLOT_W'(12);
	localparam logic [SLOT_W-1:0] SLOT_PASSI     = SLOT_W'(13);

	typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;
	typedef logic [NUM_SLOTS-1:0]               slot_mask_t;

	typedef struct packed {
		digits_t    digits;
		logic       vinto;
		slot_mask_t mask;
	} q_entry_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CONV,
		FR_PUSH
	} front_state_t;

	function automatic logic [TOKEN_W-1:0] unit_tok(logic [DIGIT_W-1:0] d);
		return TOK_UNIT_BASE + TOKEN_W'(d);
	endfunction

	function automatic logic [TOKEN_W-1:0] tens_tok(logic [DIGIT_W-1:0] d);
		return TOK_TENS_BASE + TOKEN_W'(d);
	endfunction

	function automatic logic [TOKEN_W-1:0] teen_tok(logic [DIGIT_W-1:0] d);
		return TOK_TEEN_BASE + TOKEN_W'(d);
	endfunction

	// The thousands group (digits 5 down to 3) equals exactly one.
	function automatic logic thou_is_one(digits_t d);
		return (d[5] == '0) && (d[4] == '0) && (d[3] == DIGIT_W'(1));
	endfunction

	function automatic logic [TOKEN_W-1:0] slot_token(logic [SLOT_W-1:0] slot,
			digits_t d, logic vinto);
		logic [TOKEN_W-1:0] tok;
		tok = TOK_PASSI;
		unique case (slot)
			SLOT_HEAD:      tok = vinto ? TOK_HAI_VINTO : TOK_HAI_FATTO;
			SLOT_ZERO:      tok = TOK_ZERO;
			SLOT_MIL_UNIT:  tok = unit_tok(d[6]);
			SLOT_MIL_WORD:  tok = (d[6] > DIGIT_W'(1)) ? TOK_MILIONI : TOK_MILIONE;
			SLOT_HTH_UNIT:  tok = unit_tok(d[5]);
			SLOT_HTH_CENTO: tok = TOK_CENTO;
			SLOT_TTH_TENS:  tok = (d[4] == DIGIT_W'(1)) ? teen_tok(d[3]) : tens_tok(d[4]);
			SLOT_TH_UNIT:   tok = unit_tok(d[3]);
			SLOT_TH_WORD:   tok = thou_is_one(d) ? TOK_MILLE : TOK_MILA;
			SLOT_HUN_UNIT:  tok = unit_tok(d[2]);
			SLOT_HUN_CENTO: tok = TOK_CENTO;
			SLOT_TEN_TENS:  tok = (d[1] == DIGIT_W'(1)) ? teen_tok(d[0]) : tens_tok(d[1]);
			SLOT_UNIT:      tok = unit_tok(d[0]);
			default:        tok = TOK_PASSI;
		endcase
		return tok;
	endfunction

endpackage

// File: sv/ctsw_front.sv
// Front end: accepts a count, converts it to decimal digits two bits per cycle
// and works out which token slots the item fills. Depends on ctsw_pkg.
module ctsw_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ctsw_pkg::COUNT_W-1:0] step_count,
	input  logic                       q_full,
	output logic                       push,
	output ctsw_pkg::q_entry_t         push_entry
);
	import ctsw_pkg::*;

	front_state_t            state_q, state_nxt;
	logic [COUNT_W-1:0]      bin_q;
	digits_t                 bcd_q;
	digits_t                 bcd_step;
	logic [ITER_W-1:0]       cnt_q;
	logic                    vinto_q;
	logic                    accept;
	logic                    last_iter;

	// One shift-and-add-three step of the binary to BCD conversion.
	function automatic digits_t dd_step(digits_t b, logic bit_in);
		digits_t                     adj;
		logic [NUM_DIGITS*DIGIT_W:0] shifted;
		adj = b;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (adj[i] >= DIGIT_W'(5))
				adj[i] = adj[i] + DIGIT_W'(3);
		end
		shifted = {adj, bit_in};
		return shifted[NUM_DIGITS*DIGIT_W-1:0];
	endfunction

	function automatic slot_mask_t make_mask(digits_t d, logic vinto);
		slot_mask_t m;
		logic       thou_nz;
		logic       thou_gt1;
		m        = '0;
		thou_nz  = (d[5] != '0) || (d[4] != '0) || (d[3] != '0);
		thou_gt1 = thou_nz && !thou_is_one(d);
		m[SLOT_HEAD] = 1'b1;
		if (!vinto) begin
			m[SLOT_ZERO]      = (d == '0);
			m[SLOT_MIL_UNIT]  = (d[6] != '0);
			m[SLOT_MIL_WORD]  = (d[6] != '0);
			m[SLOT_HTH_UNIT]  = (d[5] > DIGIT_W'(1));
			m[SLOT_HTH_CENTO] = (d[5] != '0);
			m[SLOT_TTH_TENS]  = (d[4] != '0);
			m[SLOT_TH_UNIT]   = (d[4] != DIGIT_W'(1)) && (d[3] != '0) && thou_gt1;
			m[SLOT_TH_WORD]   = thou_nz;
			m[SLOT_HUN_UNIT]  = (d[2] > DIGIT_W'(1));
			m[SLOT_HUN_CENTO] = (d[2] != '0);
			m[SLOT_TEN_TENS]  = (d[1] != '0);
			m[SLOT_UNIT]      = (d[1] != DIGIT_W'(1)) && (d[0] != '0);
			m[SLOT_PASSI]     = 1'b1;
		end
		return m;
	endfunction

	assign busy      = (state_q != FR_IDLE);
	assign accept    = start && !busy;
	assign last_iter = (cnt_q == ITER_W'(CONV_ITERS - 1));

	// Each conversion cycle shifts in the next bits of the count, most significant first.
	always_comb begin
		bcd_step = bcd_q;
		for (int k = 0; k < BITS_PER_IT; k++)
			bcd_step = dd_step(bcd_step, bin_q[COUNT_W-1-k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= FR_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		push      = 1'b0;
		unique case (state_q)
			FR_IDLE: begin
				if (start)
					state_nxt = FR_CONV;
			end
			FR_CONV: begin
				if (last_iter)
					state_nxt = FR_PUSH;
			end
			FR_PUSH: begin
				push = !q_full;
				if (!q_full)
					state_nxt = FR_IDLE;
			end
			default: state_nxt = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (state_q == FR_CONV) begin
			cnt_q <= cnt_q + ITER_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q   <= step_count;
			bcd_q   <= '0;
			vinto_q <= (step_count > COUNT_MAX);
		end else if (state_q == FR_CONV) begin
			bcd_q <= bcd_step;
			bin_q <= bin_q << BITS_PER_IT;
		end
	end

	assign push_entry.digits = bcd_q;
	assign push_entry.vinto  = vinto_q;
	assign push_entry.mask   = make_mask(bcd_q, vinto_q);

endmodule

// File: sv/ctsw_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on ctsw_pkg for the entry type and depth.
module ctsw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ctsw_pkg::q_entry_t push_entry,
	output logic               full,
	input  logic               pop,
	output logic               pop_valid,
	output ctsw_pkg::q_entry_t pop_entry
);
	import ctsw_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				fill_q <= fill_q + CNT_W'(1);
			else if (do_pop && !do_push)
				fill_q <= fill_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

// File: sv/ctsw_back.sv
// Back end: walks the filled token slots of one item, one token per cycle,
// and drives the registered result ports. Depends on ctsw_pkg.
module ctsw_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  ctsw_pkg::q_entry_t           q_entry,
	output logic                         q_pop,
	input  logic [ctsw_pkg::ATT_W-1:0]   att,
	output logic                         result_valid,
	output logic [ctsw_pkg::TOKEN_W-1:0] word_token,
	output logic signed [ctsw_pkg::ATT_W-1:0] attenuation,
	output logic                         last_token
);
	import ctsw_pkg::*;

	logic                active_q;
	slot_mask_t          rem_q;
	digits_t             dig_q;
	logic                vinto_q;
	logic [SLOT_W-1:0]   slot;
	slot_mask_t          rem_clr;
	logic                run_end;

	logic                out_valid_q;
	logic [TOKEN_W-1:0]  token_q;
	logic [ATT_W-1:0]    att_q;
	logic                last_q;

	// Lowest remaining slot is the next token to speak.
	always_comb begin
		slot = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (rem_q[i])
				slot = SLOT_W'(i);
		end
		rem_clr       = rem_q;
		rem_clr[slot] = 1'b0;
	end

	assign run_end = (rem_clr == '0);
	assign q_pop   = q_valid && (!active_q || run_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= active_q;
			if (q_pop)
				active_q <= 1'b1;
			else if (active_q && run_end)
				active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rem_q   <= q_entry.mask;
			dig_q   <= q_entry.digits;
			vinto_q <= q_entry.vinto;
		end else if (active_q) begin
			rem_q <= rem_clr;
		end
		token_q <= slot_token(slot, dig_q, vinto_q);
		last_q  <= run_end;
		att_q   <= att;
	end

	assign result_valid = out_valid_q;
	assign word_token   = token_q;
	assign attenuation  = att_q;
	assign last_token   = last_q;

endmodule

// File: sv/count_to_spoken_word_tokens.sv
// Step-count announcer: turns each count into its Italian spoken-word tokens.
// Flow: an accepted count is converted by the front end, pushed into the queue, then popped
// by the back end, which drives its tokens registered, one per cycle. The receiver cannot
// stall, so no result ever waits. The front end takes a new count only while idle: each item
// passes its conversion and push states first, and the push waits while the queue is full.
// Reset: volume returns to 100, the queue empties and no result is pending.
module count_to_spoken_word_tokens (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ctsw_pkg::COUNT_W-1:0] step_count,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ctsw_pkg::VOL_W-1:0]   cfg_data,
	output logic                         result_valid,
	output logic [ctsw_pkg::TOKEN_W-1:0] word_token,
	output logic signed [ctsw_pkg::ATT_W-1:0] attenuation,
	output logic                         last_token
);
	import ctsw_pkg::*;

	logic [VOL_W-1:0] vol_q;
	logic [VOL_W-1:0] vol_clamp;
	logic [ATT_W-1:0] att;
	logic             q_full;
	logic             push;
	q_entry_t         push_entry;
	logic             q_pop;
	logic             q_valid;
	q_entry_t         q_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vol_q <= VOL_RESET;
		else if (cfg_valid && cfg_ready)
			vol_q <= cfg_data;
	end

	assign vol_clamp = (vol_q > VOL_FULL) ? VOL_FULL : vol_q;
	assign att       = {1'b0, vol_clamp} - {1'b0, VOL_FULL};

	ctsw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.step_count (step_count),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ctsw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_entry  (q_entry)
	);

	ctsw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_pop        (q_pop),
		.att          (att),
		.result_valid (result_valid),
		.word_token   (word_token),
		.attenuation  (attenuation),
		.last_token   (last_token)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("front end not busy after taking an item");

	a_vinto_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && word_token == TOK_HAI_VINTO) |-> last_token)
		else $error("victory token is not the whole run");

	a_passi_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && word_token == TOK_PASSI) |-> last_token)
		else $error("run continues after the closing word");

	a_att_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (attenuation <= 0 && attenuation >= -100))
		else $error("attenuation out of range");

endmodule

// File: dv/tb_count_to_spoken_word_tokens.sv
// Self-checking testbench for the step-count announcer (count_to_spoken_word_tokens).
// Predicts each count's spoken token run and checks every token as it leaves the block.
// Depends on ctsw_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_count_to_spoken_word_tokens;
	import ctsw_pkg::*;

	localparam int RUN_CAP = 13;
	localparam int PHASE_ITEMS = 58;

	typedef struct packed {
		logic [TOKEN_W-1:0]      tok;
		logic signed [ATT_W-1:0] att;
		logic                    last;
	} spoken_token_t;

	// Predicts the token run of each accepted count and checks tokens in order.
	class token_board;
		spoken_token_t due_tokens[$];
		int unsigned volume = 100;
		int unsigned scale[7] = '{1, 10, 100, 1000, 10000, 100000, 1000000};
		int errors = 0;
		int counts = 0;
		int victories = 0;
		int checked = 0;

		function logic [TOKEN_W-1:0] word(logic [TOKEN_W-1:0] base, int unsigned d);
			return base + TOKEN_W'(d);
		endfunction

		function void note_count(logic [COUNT_W-1:0] count);
			logic [TOKEN_W-1:0] run[$];
			spoken_token_t entry;
			int unsigned val, thou, d, vol;
			int pos;
			bit teen;
			val = count;
			vol = (volume > 100) ? 100 : volume;
			thou = (val % 1000000) / 1000;
			counts++;
			if (val > COUNT_MAX) begin
				victories++;
				run.push_back(TOK_HAI_VINTO);
			end else begin
				run.push_back(TOK_HAI_FATTO);
				if (val == 0)
					run.push_back(TOK_ZERO);
				pos = 6;
				while (pos >= 0) begin
					d = (val / scale[pos]) % 10;
					teen = 0;
					if (d != 0) begin
						if (pos % 3 == 2) begin
							if (d > 1)
								run.push_back(word(TOK_UNIT_BASE, d));
							run.push_back(TOK_CENTO);
						end
						// A tens digit of one swallows the next digit into a teen word.
						if (pos % 3 == 1) begin
							if (d > 1) begin
								run.push_back(word(TOK_TENS_BASE, d));
							end else begin
								pos--;
								d = (val / scale[pos]) % 10;
								run.push_back(word(TOK_TEEN_BASE, d));
								teen = 1;
							end
						end
						if (pos == 6) begin
							run.push_back(word(TOK_UNIT_BASE, d));
							run.push_back((d > 1) ? TOK_MILIONI : TOK_MILIONE);
						end
						if (pos == 3) begin
							if (teen) begin
								run.push_back(TOK_MILA);
							end else if (thou > 1) begin
								run.push_back(word(TOK_UNIT_BASE, d));
								run.push_back(TOK_MILA);
							end else begin
								run.push_back(TOK_MILLE);
							end
						end
						if (pos == 0 && !teen)
							run.push_back(word(TOK_UNIT_BASE, d));
					end else if (pos == 3 && thou > 1) begin
						run.push_back(TOK_MILA);
					end
					pos--;
				end
				run.push_back(TOK_PASSI);
			end
			if (run.size() > RUN_CAP)
				run = run[0:RUN_CAP-1];
			foreach (run[k]) begin
				entry.tok = run[k];
				entry.att = ATT_W'(int'(vol) - 100);
				entry.last = (k == run.size() - 1);
				due_tokens.push_back(entry);
			end
		endfunction

		function void check_token(logic [TOKEN_W-1:0] tok, logic signed [ATT_W-1:0] att,
				logic last);
			spoken_token_t want;
			checked++;
			if (due_tokens.size() == 0) begin
				errors++;
				$display("%0t: unexpected token %0d att %0d last %0d, none expected",
					$time, tok, att, last);
				return;
			end
			want = due_tokens.pop_front();
			if (want.tok !== tok || want.att !== att || want.last !== last) begin
				errors++;
				$display("%0t: token mismatch, expected %0d att %0d last %0d, ",
					$time, want.tok, want.att, want.last,
					"got %0d att %0d last %0d", tok, att, last);
			end
		endfunction

		function int pending();
			return due_tokens.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [COUNT_W-1:0] step_count;
	logic cfg_valid;
	logic cfg_ready;
	logic [VOL_W-1:0] cfg_data;
	logic result_valid;
	logic [TOKEN_W-1:0] word_token;
	logic signed [ATT_W-1:0] attenuation;
	logic last_token;

	token_board board;
	bit no_gaps;
	int settings_used;
	int unsigned volume_plan[7] = '{0, 127, 57, 101, 1, 100, 0};
	int unsigned corner_counts[24] = '{0, 1, 10, 11, 19, 20, 99, 100, 200, 999, 1000,
		1001000, 2000, 10000, 11000, 21000, 100000, 101000, 1000000, 2000000,
		9999999, 10000000, 16777215, 8388608};

	count_to_spoken_word_tokens u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.step_count   (step_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.word_token   (word_token),
		.attenuation  (attenuation),
		.last_token   (last_token)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check_token(word_token, attenuation, last_token);
	end

	// Mostly short gaps, the odd long one, none at all while no_gaps is set.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Counts are biased towards sparse digit patterns full of zeros and ones,
	// where the spoken rules have most of their special cases.
	function automatic logic [COUNT_W-1:0] pick_count();
		int unsigned sel, val, d;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return COUNT_W'($urandom());
		if (sel < 15)
			return COUNT_W'($urandom_range(COUNT_MAX + 1, (1 << COUNT_W) - 1));
		if (sel < 45)
			return COUNT_W'($urandom_range(0, COUNT_MAX));
		if (sel < 60)
			return COUNT_W'($urandom_range(0, 999));
		val = 0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			d = $urandom_range(0, 3);
			if (d > 1)
				d = $urandom_range(0, 9);
			val = val * 10 + d;
		end
		return COUNT_W'(val);
	endfunction

	task automatic send_count(input logic [COUNT_W-1:0] count);
		int gap;
		gap = pick_gap();
		start <= 1'b1;
		step_count <= count;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		board.note_count(count);
		if (gap > 0) begin
			start <= 1'b0;
			step_count <= COUNT_W'($urandom());
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_volume(input logic [VOL_W-1:0] vol);
		cfg_valid <= 1'b1;
		cfg_data <= vol;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		board.volume = vol;
		settings_used++;
		cfg_valid <= 1'b0;
		cfg_data <= VOL_W'($urandom());
	endtask

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		board = new();
		no_gaps = 0;
		settings_used = 1;
		arst_n = 1'b0;
		start = 1'b0;
		step_count = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Corner counts at the reset volume.
		foreach (corner_counts[i])
			send_count(COUNT_W'(corner_counts[i]));
		drain();

		volume_plan[6] = $urandom_range(0, 127);
		foreach (volume_plan[p]) begin
			write_volume(VOL_W'(volume_plan[p]));
			no_gaps = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_count(pick_count());
				if (i == PHASE_ITEMS / 2)
					drain();
			end
			drain();
		end

		repeat (30) @(posedge clk);
		$display("Announced %0d counts, %0d of them past the maximum, over %0d volume settings.",
			board.counts, board.victories, settings_used);
		$display("Checked %0d tokens with %0d errors.", board.checked, board.errors);
		if (board.errors == 0 && board.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
